// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file fgr_checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define FGR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fgr assertion failed");

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define FGR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fgr assertion failed");

`endif

// ----- rtl/fgr_pkg.sv -----
// ---------------------------------------------------------------------------
// fgr_pkg
// Sequencer state type for the fraction reduction block.
// ---------------------------------------------------------------------------
package fgr_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,   // waiting for an input beat
    S_ALIGN,  // strip common factors of two
    S_GCD,    // binary gcd loop
    S_DIVN,   // numerator / gcd
    S_DIVD,   // denominator / gcd
    S_OUT     // result beat offered
  } fgr_state_t;

endpackage

// ----- rtl/fgr_ifs.sv -----
// ---------------------------------------------------------------------------
// fgr_ifs
// Valid/ready channels carrying the fraction in and the reduced fraction out.
// ---------------------------------------------------------------------------
interface fgr_in_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] numer_in;
  logic signed [W-1:0] denom_in;

  modport source (output valid, output numer_in, output denom_in, input ready);
  modport sink   (input valid, input numer_in, input denom_in, output ready);
endinterface

interface fgr_out_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] numer_out;
  logic        [W-2:0] denom_out;

  modport source (output valid, output numer_out, output denom_out, input ready);
  modport sink   (input valid, input numer_out, input denom_out, output ready);
endinterface

// ----- rtl/fgr_alu.sv -----
// ---------------------------------------------------------------------------
// fgr_alu
// Shared subtractor: difference and borrow, used for both the gcd
// compare/subtract and the restoring division steps.
// ---------------------------------------------------------------------------
module fgr_alu #(
  parameter int W = 32
) (
  input  logic [W:0] op_a,
  input  logic [W:0] op_b,
  output logic [W:0] diff,
  output logic       borrow
);

  always_comb begin
    {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};
  end

endmodule

// ----- rtl/fraction_gcd_reduce.sv -----
// Zero denominator gives the result beat in the cycle after accept;
//   otherwise the item passes through ALIGN (common factors of two), GCD
//   (halve/swap/subtract steps), DIVN and DIVD before the result beat.
// Throughput: one item at a time; a new beat is taken the cycle after the
//   result beat leaves. The single shared subtractor sets the figure.
// Reset: synchronous active-low rst_n returns the sequencer to idle.
// ---------------------------------------------------------------------------
// fraction_gcd_reduce
// Reduces a signed fraction to lowest terms, denominator positive unless zero.
// ---------------------------------------------------------------------------
module fraction_gcd_reduce
  import fgr_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  fgr_in_if.sink     in_ch,
  fgr_out_if.source  out_ch
);

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(WORD_BITS);

  // Flow:
  //   IDLE  - take a beat, form magnitudes and the result sign.
  //   ALIGN - shift both magnitudes right while both are even, counting k.
  //   GCD   - binary gcd on x/y: halve an even side, else subtract the
  //           smaller odd value from the larger (swap first when x < y).
  //           When x reaches zero, gcd = y << k.
  //   DIVN  - restoring division |num| / gcd, one quotient bit per cycle.
  //   DIVD  - same for |den| / gcd.
  //   OUT   - hold the result beat until taken.
  // During division x_r is the shifting dividend/quotient, y_r the remainder.
  // Zero numerator falls out naturally: gcd = |den|, giving 0/1.

  fgr_state_t        state_r, state_nxt;
  logic [W-1:0]      x_r, x_nxt;
  logic [W-1:0]      y_r, y_nxt;
  logic [W-1:0]      am_r, am_nxt;     // |numerator|
  logic [W-1:0]      bm_r, bm_nxt;     // |denominator|
  logic [W-1:0]      g_r, g_nxt;       // gcd
  logic [CW-1:0]     cnt_r, cnt_nxt;   // factor-of-two count, then bit count
  logic              neg_r, neg_nxt;   // result sign
  logic [W-1:0]      onum_r, onum_nxt;
  logic [W-2:0]      oden_r, oden_nxt;

  logic              in_fire;
  logic [W-1:0]      a_raw, b_raw, a_mag, b_mag;
  logic [W:0]        alu_a, alu_b, alu_diff;
  logic              alu_borrow;
  logic              cnt_last;
  logic [W-1:0]      rem_step, quo_step;

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign a_raw    = W'(in_ch.numer_in);
  assign b_raw    = W'(in_ch.denom_in);
  // Most negative value maps to 2^(W-1), exact in W unsigned bits.
  assign a_mag    = a_raw[W-1] ? (~a_raw + 1'b1) : a_raw;
  assign b_mag    = b_raw[W-1] ? (~b_raw + 1'b1) : b_raw;
  assign cnt_last = (cnt_r == CW'(WORD_BITS - 1));

  // Shared subtractor operands
  always_comb begin
    if (state_r == S_DIVN || state_r == S_DIVD) begin
      alu_a = {y_r, x_r[W-1]};
      alu_b = {1'b0, g_r};
    end else begin
      alu_a = {1'b0, x_r};
      alu_b = {1'b0, y_r};
    end
  end

  fgr_alu #(.W(W)) u_alu (
    .op_a   (alu_a),
    .op_b   (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

  // Restoring division step
  assign rem_step = alu_borrow ? alu_a[W-1:0] : alu_diff[W-1:0];
  assign quo_step = {x_r[W-2:0], ~alu_borrow};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (b_raw == '0) ? S_OUT : S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (x_r[0] || y_r[0]) begin
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (x_r == '0) begin
          state_nxt = S_DIVN;
        end
      end
      S_DIVN: begin
        if (cnt_last) begin
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        if (cnt_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    am_nxt   = am_r;
    bm_nxt   = bm_r;
    g_nxt    = g_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    onum_nxt = onum_r;
    oden_nxt = oden_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          x_nxt    = a_mag;
          y_nxt    = b_mag;
          am_nxt   = a_mag;
          bm_nxt   = b_mag;
          neg_nxt  = a_raw[W-1] ^ b_raw[W-1];
          cnt_nxt  = '0;
          // zero denominator: pass through
          onum_nxt = a_raw;
          oden_nxt = '0;
        end
      end
      S_ALIGN: begin
        if (!(x_r[0] || y_r[0])) begin
          x_nxt   = x_r >> 1;
          y_nxt   = y_r >> 1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_GCD: begin
        priority if (x_r == '0) begin
          g_nxt   = y_r << cnt_r;
          x_nxt   = am_r;
          y_nxt   = '0;
          cnt_nxt = '0;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (alu_borrow) begin
          x_nxt = y_r;
          y_nxt = x_r;
        end else begin
          x_nxt = alu_diff[W-1:0];
        end
      end
      S_DIVN: begin
        x_nxt   = quo_step;
        y_nxt   = rem_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          onum_nxt = quo_step;
          x_nxt    = bm_r;
          y_nxt    = '0;
          cnt_nxt  = '0;
        end
      end
      S_DIVD: begin
        x_nxt   = quo_step;
        y_nxt   = rem_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          onum_nxt = neg_r ? (~onum_r + 1'b1) : onum_r;
          oden_nxt = quo_step[W-2:0];
        end
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ch.ready      = (state_r == S_IDLE);
    out_ch.valid     = (state_r == S_OUT);
    out_ch.numer_out = onum_r;
    out_ch.denom_out = oden_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    am_r   <= am_nxt;
    bm_r   <= bm_nxt;
    g_r    <= g_nxt;
    neg_r  <= neg_nxt;
    onum_r <= onum_nxt;
    oden_r <= oden_nxt;
  end

endmodule

// ----- rtl/fgr_checker.sv -----
// ---------------------------------------------------------------------------
// fgr_checker
// Port-level checks for fraction_gcd_reduce, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fgr_checker #(
  parameter int W = 32
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic [W-1:0] numer_in,
  input logic [W-1:0] denom_in,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] numer_out,
  input logic [W-2:0] denom_out
);

  // Result beat stays offered until taken.
  `FGR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // One item in flight: never ready while a result is pending.
  `FGR_ASSERT_IMP(a_one_item, clk, rst_n, in_ready, !out_valid)

  // Zero denominator passes the numerator through on the next cycle.
  `FGR_ASSERT_NXT(a_zero_den, clk, rst_n, in_valid && in_ready && denom_in == '0,
                  out_valid && numer_out == $past(numer_in) && denom_out == '0)

  // After the result beat leaves, the block takes input again.
  `FGR_ASSERT_NXT(a_back_idle, clk, rst_n, out_valid && out_ready, in_ready)

endmodule

bind fraction_gcd_reduce fgr_checker #(.W(WORD_BITS)) u_fgr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .numer_in  (in_ch.numer_in),
  .denom_in  (in_ch.denom_in),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .numer_out (out_ch.numer_out),
  .denom_out (out_ch.denom_out)
);
